[design/ftcw_pkg.sv]
// ftcw_pkg: shared types, constants and state codes for the waypoint converter
// used by ftcw_ctrl, ftcw_dp and frenet_to_cartesian_waypoints
package ftcw_pkg;

	localparam int MaxWaypointsDefault = 256;
	localparam int CordicStepsDefault  = 24;
	localparam int CoordW  = 25;
	localparam int ArcW    = 24;
	localparam int OffW    = 14;
	localparam int CountW  = 9;
	localparam int IdxInW  = 8;
	localparam int AccW    = 64;
	localparam int ShW     = 5;
	localparam logic signed [AccW-1:0] InvGain = 64'sd652032874;
	localparam logic signed [AccW-1:0] Half    = 64'sd536870912;
	localparam logic [0:0] ReqLoad    = 1'b0;
	localparam logic [0:0] ReqConvert = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SEG_RD,
		ST_NXT_RD,
		ST_PREP,
		ST_MUL,
		ST_VEC,
		ST_ROT,
		ST_OUT,
		ST_HOLD
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;        // write the held waypoint
		logic capture;     // register the input item
		logic scan_rd;     // read entry at scan pointer
		logic scan_cmp;    // compare read entry with query and advance scan pointer
		logic seg_rd;      // read segment start
		logic nxt_rd;      // read segment end
		logic prep;        // form dx, dy, segs
		logic mul;         // gain products and prescale
		logic vec_step;
		logic rot_step;
		logic finish;      // round, add, saturate into output register
		logic scan_reset;
		logic step_reset;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic step_last;
	} stat_t;

endpackage

[design/ftcw_ctrl.sv]
// ftcw_ctrl: sequencer for load, scan, cordic vectoring/rotation and output
// depends on ftcw_pkg
module ftcw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            in_convert,
	input  logic            out_fire,
	input  ftcw_pkg::stat_t stat,
	output ftcw_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            out_valid
);

	ftcw_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ftcw_pkg::ST_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ftcw_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.capture = 1'b1;
					if (in_convert) begin
						cmd.scan_reset = 1'b1;
						state_next = ftcw_pkg::ST_SCAN_RD;
					end
				end
			end
			ftcw_pkg::ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_next = ftcw_pkg::ST_SCAN_CMP;
			end
			ftcw_pkg::ST_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_next = stat.scan_done ? ftcw_pkg::ST_SEG_RD : ftcw_pkg::ST_SCAN_RD;
			end
			ftcw_pkg::ST_SEG_RD: begin
				cmd.seg_rd = 1'b1;
				state_next = ftcw_pkg::ST_NXT_RD;
			end
			ftcw_pkg::ST_NXT_RD: begin
				cmd.nxt_rd = 1'b1;
				state_next = ftcw_pkg::ST_PREP;
			end
			ftcw_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_next = ftcw_pkg::ST_MUL;
			end
			ftcw_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.step_reset = 1'b1;
				state_next = ftcw_pkg::ST_VEC;
			end
			ftcw_pkg::ST_VEC: begin
				cmd.vec_step = 1'b1;
				if (stat.step_last) begin
					cmd.step_reset = 1'b1;
					state_next = ftcw_pkg::ST_ROT;
				end
			end
			ftcw_pkg::ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (stat.step_last) state_next = ftcw_pkg::ST_OUT;
			end
			ftcw_pkg::ST_OUT: begin
				cmd.finish = 1'b1;
				state_next = ftcw_pkg::ST_HOLD;
			end
			ftcw_pkg::ST_HOLD: begin
				out_valid = 1'b1;
				if (out_fire) state_next = ftcw_pkg::ST_IDLE;
			end
			default: state_next = ftcw_pkg::ST_IDLE;
		endcase
		// load items are written in the cycle after capture
		if (state_q == ftcw_pkg::ST_IDLE) cmd.load = 1'b0;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ftcw_pkg::ST_HOLD && !out_fire |=> state_q == ftcw_pkg::ST_HOLD)
		else $error("result dropped before transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> state_q == ftcw_pkg::ST_IDLE)
		else $error("capture outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ftcw_pkg::ST_OUT |=> out_valid)
		else $error("finish not followed by valid result");

endmodule

[design/ftcw_dp.sv]
// ftcw_dp: waypoint table, scan pointer, shared cordic shift-add unit, output register
// depends on ftcw_pkg
module ftcw_dp #(
	parameter int MAX_WAYPOINTS = ftcw_pkg::MaxWaypointsDefault,
	parameter int CORDIC_STEPS  = ftcw_pkg::CordicStepsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ftcw_pkg::cmd_t                    cmd,
	output ftcw_pkg::stat_t                   stat,
	input  logic [ftcw_pkg::CountW-1:0]       waypoint_count,
	input  logic [ftcw_pkg::IdxInW-1:0]       wp_index,
	input  logic [ftcw_pkg::ArcW-1:0]         wp_s,
	input  logic signed [ftcw_pkg::CoordW-1:0] wp_x,
	input  logic signed [ftcw_pkg::CoordW-1:0] wp_y,
	input  logic [ftcw_pkg::ArcW-1:0]         query_s,
	input  logic signed [ftcw_pkg::OffW-1:0]  query_d,
	input  logic                              load_now,
	output logic signed [ftcw_pkg::CoordW-1:0] out_x,
	output logic signed [ftcw_pkg::CoordW-1:0] out_y,
	output logic [ftcw_pkg::IdxInW-1:0]       segment_index,
	output logic                              saturated
);

	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int KW = $clog2(MAX_WAYPOINTS + 1);
	localparam int SW = $clog2(CORDIC_STEPS);
	localparam int MemW = ftcw_pkg::ArcW + 2 * ftcw_pkg::CoordW;
	localparam int AccW = ftcw_pkg::AccW;
	localparam logic signed [AccW-1:0] CoordMax = 64'sd16777215;
	localparam logic signed [AccW-1:0] CoordMin = -64'sd16777216;

	logic [MemW-1:0] mem [MAX_WAYPOINTS];
	logic [MemW-1:0] rd_q;
	logic [AW-1:0]   rd_addr;

	logic [ftcw_pkg::ArcW-1:0]         qs_q;
	logic signed [ftcw_pkg::OffW-1:0]  qd_q;
	logic [KW-1:0]  k_q;
	logic [KW-1:0]  n_eff;
	logic [AW-1:0]  seg_q;
	logic [AW-1:0]  nxt_idx;
	logic [ftcw_pkg::ArcW-1:0]         seg_s_q;
	logic signed [ftcw_pkg::CoordW-1:0] seg_x_q, seg_y_q;
	logic signed [ftcw_pkg::CoordW:0]  dx_q, dy_q;
	logic signed [ftcw_pkg::ArcW:0]    segs_q;
	logic zero_q;
	logic signed [AccW-1:0] vx_q, vy_q, u_q, v_q;
	logic [SW-1:0] step_q;
	logic [CORDIC_STEPS-1:0] cw_q;

	logic [ftcw_pkg::ArcW-1:0]         rd_s;
	logic signed [ftcw_pkg::CoordW-1:0] rd_x, rd_y;
	assign rd_s = rd_q[ftcw_pkg::ArcW-1:0];
	assign rd_x = rd_q[ftcw_pkg::ArcW +: ftcw_pkg::CoordW];
	assign rd_y = rd_q[ftcw_pkg::ArcW+ftcw_pkg::CoordW +: ftcw_pkg::CoordW];

	always_comb begin
		if (waypoint_count == '0) n_eff = KW'(1);
		else if (32'(waypoint_count) > MAX_WAYPOINTS) n_eff = KW'(MAX_WAYPOINTS);
		else n_eff = KW'(waypoint_count);
	end

	assign nxt_idx = (32'(seg_q) + 1 >= 32'(n_eff)) ? '0 : AW'(32'(seg_q) + 1);

	always_comb begin
		rd_addr = k_q[AW-1:0];
		if (cmd.seg_rd) rd_addr = seg_q;
		else if (cmd.nxt_rd) rd_addr = nxt_idx;
	end

	// single-port table: write on load, registered read
	always_ff @(posedge clk) begin
		if (load_now && 32'(wp_index) < MAX_WAYPOINTS)
			mem[AW'(wp_index)] <= {wp_y, wp_x, wp_s};
		if (cmd.scan_rd || cmd.seg_rd || cmd.nxt_rd) rd_q <= mem[rd_addr];
	end

	// scan: stop at first s >= query or at count
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qs_q <= query_s;
			qd_q <= query_d;
		end
		if (cmd.scan_reset) begin
			k_q <= '0;
		end else if (cmd.scan_cmp) begin
			if (qs_q > rd_s) k_q <= k_q + KW'(1);
		end
	end

	logic cmp_stop;
	assign cmp_stop = !(qs_q > rd_s) || (k_q + KW'(1) >= n_eff);
	assign stat = '{scan_done: cmp_stop, step_last: (32'(step_q) == CORDIC_STEPS - 1)};

	always_ff @(posedge clk) begin
		if (cmd.scan_cmp && !(qs_q > rd_s) && k_q != '0)
			seg_q <= AW'(k_q - KW'(1));
		else if (cmd.scan_cmp && !(qs_q > rd_s))
			seg_q <= '0;
		else if (cmd.scan_cmp)
			seg_q <= AW'(k_q);
	end

	logic signed [ftcw_pkg::CoordW:0] dx_w, dy_w;
	always_ff @(posedge clk) begin
		if (cmd.nxt_rd) begin
			seg_s_q <= rd_s;
			seg_x_q <= rd_x;
			seg_y_q <= rd_y;
		end
		if (cmd.prep) begin
			dx_q <= dx_w;
			dy_q <= dy_w;
			segs_q <= $signed({1'b0, qs_q}) - $signed({1'b0, seg_s_q});
		end
	end
	assign dx_w = $signed({rd_x[ftcw_pkg::CoordW-1], rd_x}) -
		$signed({seg_x_q[ftcw_pkg::CoordW-1], seg_x_q});
	assign dy_w = $signed({rd_y[ftcw_pkg::CoordW-1], rd_y}) -
		$signed({seg_y_q[ftcw_pkg::CoordW-1], seg_y_q});

	// shared shift-add cordic step
	logic signed [AccW-1:0] sh_vx, sh_vy, sh_u, sh_v, u0, v0;
	assign sh_vx = vx_q >>> step_q;
	assign sh_vy = vy_q >>> step_q;
	assign sh_u  = u_q >>> step_q;
	assign sh_v  = v_q >>> step_q;
	assign u0 = AccW'(segs_q) * ftcw_pkg::InvGain;
	assign v0 = -(AccW'(qd_q) * ftcw_pkg::InvGain);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			zero_q <= (dx_q == '0) && (dy_q == '0);
			vx_q <= (dx_q < 0) ? -(AccW'(dx_q) <<< 30) : (AccW'(dx_q) <<< 30);
			vy_q <= (dx_q < 0) ? -(AccW'(dy_q) <<< 30) : (AccW'(dy_q) <<< 30);
			u_q <= (dx_q < 0 && !(dx_q == '0 && dy_q == '0)) ? -u0 : u0;
			v_q <= (dx_q < 0 && !(dx_q == '0 && dy_q == '0)) ? -v0 : v0;
		end else if (cmd.vec_step) begin
			cw_q[step_q] <= vy_q >= 0;
			if (vy_q >= 0) begin
				vx_q <= vx_q + sh_vy;
				vy_q <= vy_q - sh_vx;
			end else begin
				vx_q <= vx_q - sh_vy;
				vy_q <= vy_q + sh_vx;
			end
		end else if (cmd.rot_step && !zero_q) begin
			if (cw_q[step_q]) begin
				u_q <= u_q - sh_v;
				v_q <= v_q + sh_u;
			end else begin
				u_q <= u_q + sh_v;
				v_q <= v_q - sh_u;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= '0;
		else if (cmd.step_reset) step_q <= '0;
		else if (cmd.vec_step || cmd.rot_step) step_q <= step_q + SW'(1);
	end

	// round, add, saturate
	logic signed [AccW-1:0] ox, oy, rx, ry;
	assign ox = (u_q + ftcw_pkg::Half) >>> 30;
	assign oy = (v_q + ftcw_pkg::Half) >>> 30;
	assign rx = AccW'(seg_x_q) + ox;
	assign ry = AccW'(seg_y_q) + oy;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_x <= (rx > CoordMax) ? CoordMax[ftcw_pkg::CoordW-1:0] :
				(rx < CoordMin) ? CoordMin[ftcw_pkg::CoordW-1:0] : rx[ftcw_pkg::CoordW-1:0];
			out_y <= (ry > CoordMax) ? CoordMax[ftcw_pkg::CoordW-1:0] :
				(ry < CoordMin) ? CoordMin[ftcw_pkg::CoordW-1:0] : ry[ftcw_pkg::CoordW-1:0];
			saturated <= rx > CoordMax || rx < CoordMin || ry > CoordMax || ry < CoordMin;
			segment_index <= ftcw_pkg::IdxInW'(seg_q);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_cmp |-> k_q < n_eff)
		else $error("scan pointer past loaded count");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nxt_rd |-> 32'(nxt_idx) < 32'(n_eff))
		else $error("segment end outside loop");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vec_step |-> !cmd.rot_step)
		else $error("cordic unit shared by two passes");

endmodule

[design/frenet_to_cartesian_waypoints.sv]
// frenet_to_cartesian_waypoints: a load item is written from a register, and
// s_tready drops while it is written; a conversion scans waypoints (one table
// read and one compare each, single-port table), then runs the cordic vectoring
// and rotation passes, and holds the result until it is transferred
// arst_n clears the sequencer and the count register (to 1); table contents
// stay undefined until written
module frenet_to_cartesian_waypoints #(
	parameter int MAX_WAYPOINTS = ftcw_pkg::MaxWaypointsDefault,
	parameter int CORDIC_STEPS  = ftcw_pkg::CordicStepsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// tdata: wp_index[7:0], wp_s[31:8], wp_x[56:32], wp_y[81:57],
	// query_s[105:82], query_d[119:106]
	input  logic [119:0]  s_tdata,
	input  logic          s_tuser,   // req_type
	output logic          m_tvalid,
	input  logic          m_tready,
	// tdata: out_x[24:0], out_y[49:25], segment_index[57:50], zero fill
	output logic [63:0]   m_tdata,
	output logic          m_tuser,   // saturated
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [8:0]    cfg_data
);

	ftcw_pkg::cmd_t  cmd;
	ftcw_pkg::stat_t stat;
	logic busy, in_fire, load_q;
	logic [ftcw_pkg::CountW-1:0] count_q;
	logic [ftcw_pkg::IdxInW-1:0] idx_q;
	logic [ftcw_pkg::ArcW-1:0]   s_q;
	logic signed [ftcw_pkg::CoordW-1:0] x_q, y_q, ox, oy;
	logic [ftcw_pkg::IdxInW-1:0] seg;

	assign s_tready = !busy && !load_q;
	assign in_fire = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ftcw_pkg::CountW'(1);
			load_q <= 1'b0;
		end else begin
			if (cfg_valid) count_q <= cfg_data;
			load_q <= in_fire && s_tuser == ftcw_pkg::ReqLoad;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q <= s_tdata[7:0];
			s_q <= s_tdata[31:8];
			x_q <= s_tdata[56:32];
			y_q <= s_tdata[81:57];
		end
	end

	ftcw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_convert(s_tuser == ftcw_pkg::ReqConvert), .out_fire(m_tvalid && m_tready),
		.stat(stat), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
	);

	ftcw_dp #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .waypoint_count(count_q),
		.wp_index(idx_q), .wp_s(s_q), .wp_x(x_q), .wp_y(y_q),
		.query_s(s_tdata[105:82]), .query_d(s_tdata[119:106]), .load_now(load_q),
		.out_x(ox), .out_y(oy), .segment_index(seg), .saturated(m_tuser)
	);

	assign m_tdata = {6'b0, seg, oy, ox};

endmodule
